[rtl/core/bcd_pkg.sv]
// shared types, codes and crc function for the block crc deframer
package bcd_pkg;

  localparam logic [15:0] CRC_POLY = 16'h3D65;
  localparam int unsigned PL_W     = 9;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_OK       = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TRUNC    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_DATA   = 3'b001,
    PH_CRC_HI = 3'b010,
    PH_CRC_LO = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frm_start;
    logic       frm_end;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } res_t;

  // up to two results per item, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r1;
    res_t       r0;
  } push_t;

  // msb-first crc over one byte
  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/block_crc_deframer_core.sv]
// top level of the block crc deframer
//
//  channel | direction | transfer content
//  in_     | input     | in_byte_in, in_frame_start, in_frame_end
//  out_    | output    | out_byte, out_kind, out_last
//
// one byte per cycle; the core writes up to two results per byte into the
// four-entry result queue and holds the input only while the queue holds
// more than two entries (two-result bytes close together, or out_ready low).
// a byte passes the input register, then the core into the result queue.
// synchronous active-low reset closes any frame and empties the queue.
// out_ready low fills the queue, then in_ready drops; nothing is lost.
module block_crc_deframer_core
  import bcd_pkg::*;
#(
  parameter int unsigned FIRST_BLOCK_BYTES = 10,
  parameter int unsigned NEXT_BLOCK_BYTES  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_take;
  logic  room;
  push_t push;
  res_t  out_res;

  assign in_item = '{data: in_byte_in, frm_start: in_frame_start, frm_end: in_frame_end};

  bcd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  bcd_core #(
    .FIRST_BLOCK_BYTES (FIRST_BLOCK_BYTES),
    .NEXT_BLOCK_BYTES  (NEXT_BLOCK_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .room       (room),
    .item_take  (item_take),
    .push       (push)
  );

  bcd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte = out_res.data;
  assign out_kind = out_res.kind;
  assign out_last = out_res.last;

endmodule

[rtl/core/bcd_in_reg.sv]
// input register stage holding one raw byte until the core takes it
module bcd_in_reg
  import bcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/core/bcd_core.sv]
// frame state, crc check and result generation for one byte per cycle while the queue has room
module bcd_core
  import bcd_pkg::*;
#(
  parameter int unsigned FIRST_BLOCK_BYTES = 10,
  parameter int unsigned NEXT_BLOCK_BYTES  = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  input  item_t item,
  input  logic  room,
  output logic  item_take,
  output push_t push
);

  localparam int unsigned BL_MAX =
    (FIRST_BLOCK_BYTES > NEXT_BLOCK_BYTES) ? FIRST_BLOCK_BYTES : NEXT_BLOCK_BYTES;
  localparam int unsigned BL_W = $clog2(BL_MAX + 1);

  logic            act_r, act_nxt;
  logic [PL_W-1:0] pl_r, pl_nxt;
  logic [BL_W-1:0] bl_r, bl_nxt;
  phase_t          ph_r, ph_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic [7:0]      hi_r, hi_nxt;

  res_t        res [2];
  logic [1:0]  n;
  logic        fin;
  res_t        trunc_res;

  assign item_take = item_valid && room;
  assign trunc_res = '{data: 8'h00, kind: KIND_TRUNC, last: 1'b1};

  always_comb begin
    act_nxt = act_r;
    pl_nxt  = pl_r;
    bl_nxt  = bl_r;
    ph_nxt  = ph_r;
    acc_nxt = acc_r;
    hi_nxt  = hi_r;
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    fin     = 1'b0;
    if (item_take) begin
      if (item.frm_start) begin
        // restart closes an open frame first
        if (act_nxt) begin
          res[n[0]] = trunc_res;
          n         = n + 2'd1;
        end
        act_nxt = 1'b0;
        pl_nxt  = '0;
        bl_nxt  = '0;
        ph_nxt  = PH_DATA;
        acc_nxt = '0;
        hi_nxt  = '0;
        if (item.frm_end) begin
          res[n[0]] = trunc_res;
          n         = n + 2'd1;
          fin       = 1'b1;
        end else begin
          act_nxt = 1'b1;
          pl_nxt  = {1'b0, item.data} + PL_W'(1);
          bl_nxt  = (pl_nxt < PL_W'(FIRST_BLOCK_BYTES)) ? BL_W'(pl_nxt)
                                                          : BL_W'(FIRST_BLOCK_BYTES);
        end
      end
      if (!fin && act_nxt) begin
        case (ph_nxt)
          PH_DATA: begin
            acc_nxt   = crc_upd(acc_nxt, item.data);
            res[n[0]] = '{data: item.data, kind: KIND_PAYLOAD, last: 1'b0};
            n         = n + 2'd1;
            if (pl_nxt != '0) begin
              pl_nxt = pl_nxt - PL_W'(1);
            end
            if (bl_nxt != '0) begin
              bl_nxt = bl_nxt - BL_W'(1);
            end
            if (bl_nxt == '0) begin
              ph_nxt = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            hi_nxt = item.data;
            ph_nxt = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            if ({hi_nxt, item.data} != ~acc_nxt) begin
              res[n[0]] = '{data: 8'h00, kind: KIND_MISMATCH, last: 1'b1};
              n         = n + 2'd1;
              fin       = 1'b1;
            end else if (pl_nxt == '0) begin
              res[n[0]] = '{data: 8'h00, kind: KIND_OK, last: 1'b1};
              n         = n + 2'd1;
              fin       = 1'b1;
            end else begin
              bl_nxt  = (pl_nxt < PL_W'(NEXT_BLOCK_BYTES)) ? BL_W'(pl_nxt)
                                                             : BL_W'(NEXT_BLOCK_BYTES);
              acc_nxt = '0;
              hi_nxt  = '0;
              ph_nxt  = PH_DATA;
            end
          end
          default: begin
            ph_nxt = PH_DATA;
          end
        endcase
        if (!fin && item.frm_end) begin
          res[n[0]] = trunc_res;
          n         = n + 2'd1;
          fin       = 1'b1;
        end
        if (fin) begin
          act_nxt = 1'b0;
          pl_nxt  = '0;
          bl_nxt  = '0;
          ph_nxt  = PH_DATA;
          acc_nxt = '0;
          hi_nxt  = '0;
        end
      end
    end
  end

  assign push.cnt = n;
  assign push.r0  = res[0];
  assign push.r1  = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      pl_r  <= '0;
      bl_r  <= '0;
      ph_r  <= PH_DATA;
      acc_r <= '0;
      hi_r  <= '0;
    end else begin
      act_r <= act_nxt;
      pl_r  <= pl_nxt;
      bl_r  <= bl_nxt;
      ph_r  <= ph_nxt;
      acc_r <= acc_nxt;
      hi_r  <= hi_nxt;
    end
  end

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.frm_start && !item.frm_end |=> act_r)
    else $error("frame start without end did not open a frame");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.frm_end |=> !act_r)
    else $error("frame still open after end flag");

  a_crc_phase_open: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != PH_DATA |-> act_r)
    else $error("crc phase advanced with no frame open");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !act_r |-> (pl_r == '0) && (bl_r == '0) && (acc_r == '0))
    else $error("closed frame left counters or crc behind");

endmodule

[rtl/core/bcd_out_fifo.sv]
// four-entry result queue taking up to two results per cycle
module bcd_out_fifo
  import bcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             pop;

  // room for two more is judged on the registered count only
  assign room      = cnt_r <= (PTR_W + 1)'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = mem[rd_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_r + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(push.cnt);
      rd_r  <= rd_r + PTR_W'(pop);
      cnt_r <= cnt_r + (PTR_W + 1)'(push.cnt) - (PTR_W + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W + 1)'(DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("results pushed without room");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.last == (out_res.kind != KIND_PAYLOAD)))
    else $error("last flag disagrees with result kind");

endmodule

[tb/tb_top.sv]
// self-checking testbench for block_crc_deframer_core: frame traffic against a bytewise deframer model
`timescale 1ns / 1ps

module tb_top
  import bcd_pkg::*;
();

  localparam int unsigned FIRST_BLK  = 10;
  localparam int unsigned NEXT_BLK   = 16;
  localparam logic [15:0] POLY       = 16'h3D65;
  localparam int          MAX_SHOWN  = 10;
  localparam int          STALL_LIMIT = 1000;
  localparam int          RAND_ITEMS = 850;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_in = 8'h00;
  logic       in_frame_start = 1'b0;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  block_crc_deframer_core #(
    .FIRST_BLOCK_BYTES(FIRST_BLK),
    .NEXT_BLOCK_BYTES (NEXT_BLK)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_in    (in_byte_in),
    .in_frame_start(in_frame_start),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_last      (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // deframer state as seen by the predictor
  logic        frm_open = 1'b0;
  logic [8:0]  pay_left = '0;
  logic [4:0]  blk_left = '0;
  phase_t      phase = PH_DATA;
  logic [15:0] crc_run = '0;
  logic [7:0]  crc_hi = '0;

  res_t        status_q[$];
  logic [7:0]  frm[$];

  int n_items = 0;
  int n_err = 0;
  int n_ok = 0;
  int n_bad = 0;
  int n_trunc = 0;
  int n_pay = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  bit src_idle_on = 1'b1;
  bit sink_stall_on = 1'b1;
  res_t want;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] blk_of(input logic [8:0] left, input int unsigned lim);
    return (left < lim) ? left[4:0] : lim[4:0];
  endfunction

  function automatic void add_status(input logic [7:0] b, input kind_t k, input logic l);
    res_t r;
    r.data = b;
    r.kind = k;
    r.last = l;
    status_q.insert(status_q.size(), r);
  endfunction

  function automatic void close_frame_state();
    frm_open = 1'b0;
    pay_left = '0;
    blk_left = '0;
    phase    = PH_DATA;
    crc_run  = '0;
    crc_hi   = '0;
  endfunction

  // expected results for one accepted raw byte
  function automatic void predict_byte(input logic [7:0] b, input logic st, input logic en);
    logic [15:0] rx_crc;
    if (st) begin
      if (frm_open) begin
        add_status(8'h00, KIND_TRUNC, 1'b1);
      end
      close_frame_state();
      if (en) begin
        add_status(8'h00, KIND_TRUNC, 1'b1);
        return;
      end
      frm_open = 1'b1;
      pay_left = {1'b0, b} + 9'd1;
      blk_left = blk_of(pay_left, FIRST_BLK);
    end
    if (!frm_open) begin
      return;
    end
    case (phase)
      PH_DATA: begin
        crc_run = crc_step(crc_run, b);
        add_status(b, KIND_PAYLOAD, 1'b0);
        if (pay_left > 0) pay_left--;
        if (blk_left > 0) blk_left--;
        if (blk_left == 0) phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi = b;
        phase  = PH_CRC_LO;
      end
      default: begin
        rx_crc = {crc_hi, b};
        if (rx_crc != ~crc_run) begin
          add_status(8'h00, KIND_MISMATCH, 1'b1);
          close_frame_state();
          return;
        end
        if (pay_left == 0) begin
          add_status(8'h00, KIND_OK, 1'b1);
          close_frame_state();
          return;
        end
        blk_left = blk_of(pay_left, NEXT_BLK);
        crc_run  = '0;
        crc_hi   = '0;
        phase    = PH_DATA;
      end
    endcase
    if (en) begin
      add_status(8'h00, KIND_TRUNC, 1'b1);
      close_frame_state();
    end
  endfunction

  function automatic int src_gap();
    int r;
    if (!src_idle_on) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [7:0] rnd_byte();
    int r;
    r = $urandom_range(15, 0);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // payload of len+1 bytes with a complemented crc after every block
  function automatic void build_frame(input logic [7:0] len);
    logic [15:0] c;
    logic [15:0] cv;
    logic [7:0]  d;
    int          cnt;
    int unsigned lim;
    frm.delete();
    c   = '0;
    cnt = 0;
    lim = FIRST_BLK;
    for (int i = 0; i <= int'(len); i++) begin
      d = (i == 0) ? len : rnd_byte();
      frm.insert(frm.size(), d);
      c = crc_step(c, d);
      cnt++;
      if (cnt == lim || i == int'(len)) begin
        cv = ~c;
        frm.insert(frm.size(), cv[15:8]);
        frm.insert(frm.size(), cv[7:0]);
        c   = '0;
        cnt = 0;
        lim = NEXT_BLK;
      end
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic st, input logic en);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_in     <= b;
    in_frame_start <= st;
    in_frame_end   <= en;
    do @(posedge clk); while (!in_ready);
    n_items++;
    predict_byte(b, st, en);
  endtask

  // first cnt bytes of the built frame, frame_end optionally on the last one sent
  task automatic send_frame_bytes(input int cnt, input bit end_last);
    for (int i = 0; i < cnt; i++) begin
      send_item(frm[i], i == 0, end_last && (i == cnt - 1));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
  endtask

  task automatic test_idle_bytes();
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_short_frames();
    build_frame(8'd0);
    send_frame_bytes(frm.size(), 1'b1);
    build_frame(8'd1);
    frm[1] = 8'hFF;
    build_frame(8'd1);
    send_frame_bytes(frm.size(), 1'b0);
    // end on the crc high byte
    build_frame(8'd0);
    send_frame_bytes(2, 1'b1);
  endtask

  task automatic test_restart();
    build_frame(8'd5);
    send_frame_bytes(3, 1'b0);
    // restart of an open frame that also ends at once
    send_item(8'h07, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_truncation();
    send_item(8'd3, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_crc_errors();
    build_frame(8'd0);
    frm[2] = frm[2] ^ 8'h01;
    send_frame_bytes(frm.size(), 1'b0);
    // bad first block crc of a longer frame, also ended early
    build_frame(8'd12);
    frm[FIRST_BLK] = frm[FIRST_BLK] ^ 8'h80;
    send_frame_bytes(FIRST_BLK + 2, 1'b1);
  endtask

  task automatic test_block_edges();
    logic [7:0] lens[6];
    lens = '{8'd8, 8'd9, 8'd10, 8'd25, 8'd26, 8'd255};
    foreach (lens[i]) begin
      build_frame(lens[i]);
      send_frame_bytes(frm.size(), 1'($urandom_range(1, 0)));
    end
  endtask

  task automatic test_random_traffic();
    int r;
    int k;
    logic [7:0] len;
    while (n_items < RAND_ITEMS) begin
      if ($urandom_range(99, 0) < 12) src_idle_on = !src_idle_on;
      if ($urandom_range(99, 0) < 12) sink_stall_on = !sink_stall_on;
      len = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(90, 31)) : 8'($urandom_range(30, 0));
      build_frame(len);
      r = $urandom_range(99, 0);
      if (r < 55) begin
        send_frame_bytes(frm.size(), 1'($urandom_range(1, 0)));
      end else if (r < 70) begin
        k = $urandom_range(frm.size() - 1, 0);
        frm[k] = frm[k] ^ (8'h01 << $urandom_range(7, 0));
        send_frame_bytes(frm.size(), 1'($urandom_range(1, 0)));
      end else if (r < 82) begin
        send_frame_bytes($urandom_range(frm.size() - 1, 1), 1'b1);
      end else if (r < 90) begin
        // abandoned; the next frame start closes it
        send_frame_bytes($urandom_range(frm.size() - 1, 1), 1'b0);
      end else if (r < 96) begin
        repeat ($urandom_range(4, 1)) begin
          send_item(8'($urandom), $urandom_range(7, 0) == 0, $urandom_range(3, 0) == 0);
        end
      end else begin
        wait_drained();
      end
    end
  endtask

  // result side: random stalls, short mostly
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (sink_stall_on && $urandom_range(99, 0) < 25) begin
      hold_cnt  <= ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(2, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        if (n_err < MAX_SHOWN) begin
          $display("unexpected transfer: byte %02h kind %0d last %0b", out_byte, out_kind,
                   out_last);
        end
        n_err++;
      end else begin
        want = status_q.pop_front();
        if (out_byte !== want.data || out_kind !== want.kind || out_last !== want.last) begin
          if (n_err < MAX_SHOWN) begin
            $display("mismatch at %0t: expected byte %02h kind %0d last %0b, got %02h %0d %0b",
                     $realtime, want.data, want.kind, want.last, out_byte, out_kind, out_last);
          end
          n_err++;
        end
        case (want.kind)
          KIND_PAYLOAD:  n_pay++;
          KIND_OK:       n_ok++;
          KIND_MISMATCH: n_bad++;
          default:       n_trunc++;
        endcase
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("block_crc_deframer_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_short_frames();
    test_restart();
    wait_drained();
    test_truncation();
    test_crc_errors();
    test_block_edges();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (status_q.size() != 0) begin
      $display("%0d expected results never arrived", status_q.size());
      n_err++;
    end
    $display("sent %0d raw bytes: %0d payload bytes, %0d frames ok, %0d crc mismatches,",
             n_items, n_pay, n_ok, n_bad);
    $display("%0d truncated frames checked; %0d errors", n_trunc, n_err);
    if (n_err == 0) begin
      $display("block_crc_deframer_core verification clean");
    end else begin
      $display("block_crc_deframer_core verification failed");
    end
    $finish;
  end

endmodule
